// File: hw/rtl/wl_pkg.sv
// wl_pkg: shared constants, types and the neighbor test for the word ladder block
// no dependencies
package wl_pkg;
  localparam int unsigned MaxLen           = 8;
  localparam int unsigned DictDepthDefault = 256;
  localparam int unsigned WordW            = 40;
  localparam int unsigned LetterW          = 5;
  localparam logic [LetterW-1:0] LetterZ   = 5'd25;
  localparam logic CmdAdd    = 1'b0;
  localparam logic CmdSearch = 1'b1;

  // compare result of the shared word unit
  typedef struct packed {
    logic same;      // equal over the active letters
    logic step;      // b equal to a, or reachable from a by one letter change
    logic full_eq;   // equal over all 40 bits
  } cmp_res_t;

  function automatic cmp_res_t word_cmp(input logic [WordW-1:0] a,
                                        input logic [WordW-1:0] b,
                                        input logic [3:0] n);
    cmp_res_t r;
    logic [3:0] diffs;
    logic       alpha;
    logic       pos_ok;
    logic [LetterW-1:0] la, lb;
    diffs  = '0;
    alpha  = 1'b0;
    pos_ok = 1'b0;
    for (int i = 0; i < MaxLen; i++) begin
      la = a[i*LetterW +: LetterW];
      lb = b[i*LetterW +: LetterW];
      if (4'(i) < n) begin
        if (la <= LetterZ) alpha = 1'b1;
        if (la != lb) begin
          diffs  = diffs + 4'd1;
          pos_ok = (lb <= LetterZ);
        end
      end
    end
    r.same    = (diffs == 4'd0);
    r.step    = (diffs == 4'd0) ? alpha : ((diffs == 4'd1) ? pos_ok : 1'b0);
    r.full_eq = (a == b);
    return r;
  endfunction
endpackage

// File: hw/rtl/word_ladder_shortest_chain.sv
// word_ladder_shortest_chain: top level, sequencer around one shared word compare unit
// depends on wl_pkg and wl_ram
//
// usage:
//  - input channel (in_valid_i/in_ready_o) carries command, word, target_word;
//    command add stores a word, command search runs the ladder search
//  - output channel (out_valid_o/out_ready_i) returns ladder_length and
//    dict_overflow, one item per search, none per add
//  - word_length_we_i/word_length_i writes the letter count; write only while idle (not enforced)
// sequencing:
//  - an add compares every entry for a duplicate before the next item is
//    accepted
//  - a search scans all entries for the target, expands the start word and
//    then every frontier word, with a bookkeeping step in S_CUR at each level
//    change; the single compare unit and the single read port of the word ram
//    set the rate
//  - the block takes one item at a time; the result sits in an output
//    register, and a stalled receiver simply holds the block busy
// reset:
//  - clears the live bits, count, overflow flag and sets word_length to 4;
//    no clearing pass is needed since live bits are flip-flops
module word_ladder_shortest_chain import wl_pkg::*; #(
  parameter int unsigned DictDepth = DictDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [WordW-1:0] word_i,
  input  logic [WordW-1:0] target_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [8:0]       ladder_length_o,
  output logic             dict_overflow_o,
  input  logic             word_length_we_i,
  input  logic [3:0]       word_length_i
);
  localparam int unsigned AW = $clog2(DictDepth);
  localparam int unsigned CW = $clog2(DictDepth + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;  // duplicate scan
  localparam logic [3:0] S_FIND   = 4'd2;  // target presence scan
  localparam logic [3:0] S_CUR    = 4'd3;  // fetch frontier index
  localparam logic [3:0] S_CURW   = 4'd4;  // fetch frontier word
  localparam logic [3:0] S_TGT    = 4'd5;  // current against target
  localparam logic [3:0] S_SWEEP  = 4'd6;  // neighbor sweep
  localparam logic [3:0] S_OUT    = 4'd7;
  localparam logic [3:0] S_CURW2  = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [3:0]       wlen_q;
  logic [3:0]       n_act;
  logic [DictDepth-1:0] live_q, live_d;
  logic [CW-1:0]    count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [WordW-1:0] w_q, w_d, t_q, t_d, cur_q, cur_d;
  logic [CW-1:0]    scan_q, scan_d;       // issue address (one ahead of data)
  logic             rd_vld_q, rd_vld_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;
  logic [CW-1:0]    head_q, head_d, tail_q, tail_d, lvl_end_q, lvl_end_d;
  logic             from_start_q, from_start_d;
  logic             found_q, found_d;
  logic [8:0]       lcount_q, lcount_d;
  logic [8:0]       res_q, res_d;
  logic             rovf_q, rovf_d;

  logic             wr_we, q_we;
  logic [AW-1:0]    wr_addr, q_addr;
  logic [WordW-1:0] wr_data, rd_data;
  logic [AW-1:0]    q_rdata;
  cmp_res_t         cres;
  logic [WordW-1:0] cmp_a, cmp_b;

  assign n_act = (wlen_q > 4'(MaxLen)) ? 4'(MaxLen) : wlen_q;

  wl_ram #(.Width(WordW), .Depth(DictDepth)) u_words (
    .clk_i, .we_i(wr_we), .addr_i(wr_addr), .wdata_i(wr_data), .rdata_o(rd_data)
  );
  wl_ram #(.Width(AW), .Depth(DictDepth)) u_queue (
    .clk_i, .we_i(q_we), .addr_i(q_addr), .wdata_i(rd_idx_q), .rdata_o(q_rdata)
  );

  // the one shared compare unit
  assign cres = word_cmp(cmp_a, cmp_b, n_act);

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign ladder_length_o = res_q;
  assign dict_overflow_o = rovf_q;

  always_comb begin
    state_d = state_q; live_d = live_q; count_d = count_q; ovf_d = ovf_q;
    w_d = w_q; t_d = t_q; cur_d = cur_q; scan_d = scan_q;
    rd_vld_d = 1'b0; rd_idx_d = rd_idx_q;
    head_d = head_q; tail_d = tail_q; lvl_end_d = lvl_end_q;
    from_start_d = from_start_q; found_d = found_q; lcount_d = lcount_q;
    res_d = res_q; rovf_d = rovf_q;
    wr_we = 1'b0; wr_addr = scan_q[AW-1:0]; wr_data = w_q;
    q_we = 1'b0; q_addr = head_q[AW-1:0];
    cmp_a = cur_q; cmp_b = rd_data;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          w_d = word_i; t_d = target_word_i; scan_d = '0; found_d = 1'b0;
          state_d = (command_i == CmdAdd) ? S_ADD : S_FIND;
        end
      end
      S_ADD: begin
        cmp_a = w_q;
        if (rd_vld_q && live_q[rd_idx_q] && cres.full_eq) found_d = 1'b1;
        if (scan_q < CW'(DictDepth)) begin
          rd_vld_d = 1'b1; rd_idx_d = scan_q[AW-1:0]; scan_d = scan_q + 1'b1;
        end else if (!rd_vld_q) begin
          // all reads returned
          if (!found_q) begin
            if (count_q >= CW'(DictDepth)) ovf_d = 1'b1;
            else begin
              wr_we = 1'b1; wr_addr = count_q[AW-1:0];
              live_d[count_q[AW-1:0]] = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          state_d = S_IDLE;
        end
      end
      S_FIND: begin
        cmp_a = t_q;
        if (rd_vld_q && live_q[rd_idx_q] && cres.same) found_d = 1'b1;
        if (scan_q < CW'(DictDepth)) begin
          rd_vld_d = 1'b1; rd_idx_d = scan_q[AW-1:0]; scan_d = scan_q + 1'b1;
        end else if (!rd_vld_q) begin
          if (!found_q || n_act == 4'd0) begin
            res_d = '0; state_d = S_OUT;
          end else begin
            cur_d = w_q; from_start_d = 1'b1; head_d = '0; tail_d = '0;
            lvl_end_d = '0; lcount_d = 9'd1; state_d = S_TGT;
          end
        end
      end
      S_CUR: begin
        // level bookkeeping between frontier words
        if (head_q >= lvl_end_q) begin
          if (head_q >= tail_q) begin
            res_d = '0; state_d = S_OUT;
          end else begin
            lcount_d = lcount_q + 9'd1; lvl_end_d = tail_q;
          end
        end else begin
          q_addr = head_q[AW-1:0]; head_d = head_q + 1'b1; state_d = S_CURW;
        end
      end
      S_CURW: begin
        wr_addr = q_rdata; state_d = S_CURW2;
      end
      S_CURW2: begin
        cur_d = rd_data; state_d = S_TGT;
      end
      S_TGT: begin
        cmp_b = t_q;
        if (cres.step) begin
          res_d = lcount_q + 9'd1; state_d = S_OUT;
        end else begin
          scan_d = '0; state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        q_addr = tail_q[AW-1:0];
        if (rd_vld_q && live_q[rd_idx_q] && cres.step) begin
          live_d[rd_idx_q] = 1'b0;
          if (tail_q < CW'(DictDepth)) begin
            q_we = 1'b1; tail_d = tail_q + 1'b1;
          end
        end
        if (scan_q < CW'(DictDepth)) begin
          rd_vld_d = 1'b1; rd_idx_d = scan_q[AW-1:0]; scan_d = scan_q + 1'b1;
        end else if (!rd_vld_q) begin
          if (from_start_q) begin
            from_start_d = 1'b0; lvl_end_d = tail_d;
            if (tail_d == '0) begin
              res_d = '0; state_d = S_OUT;
            end else lcount_d = lcount_q + 9'd1;
          end
          if (!from_start_q || tail_d != '0) state_d = S_CUR;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          live_d = '0; count_d = '0; ovf_d = 1'b0; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_SWEEP || state_q == S_ADD || state_q == S_FIND)
      if (scan_q < CW'(DictDepth)) wr_addr = scan_q[AW-1:0];
    // capture the overflow flag as the result is presented
    if (state_d == S_OUT && state_q != S_OUT) rovf_d = ovf_q;
  end

  // overflow flag is registered into output on entering the output state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; live_q <= '0; count_q <= '0; ovf_q <= 1'b0;
      wlen_q <= 4'd4; rd_vld_q <= 1'b0;
    end else begin
      state_q <= state_d; live_q <= live_d; count_q <= count_d;
      ovf_q <= ovf_d; rd_vld_q <= rd_vld_d;
      if (word_length_we_i) wlen_q <= word_length_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d; t_q <= t_d; cur_q <= cur_d; scan_q <= scan_d; rd_idx_q <= rd_idx_d;
    head_q <= head_d; tail_q <= tail_d; lvl_end_q <= lvl_end_d;
    from_start_q <= from_start_d; found_q <= found_d; lcount_q <= lcount_d;
    res_q <= res_d;
    rovf_q <= rovf_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DictDepth)) else $error("count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> (count_q == '0 && live_q == '0))
    else $error("dictionary not cleared after search");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(ladder_length_o))
    else $error("result changed while stalled");
endmodule

// File: hw/rtl/wl_ram.sv
// wl_ram: generic single-port ram with registered read
// no dependencies
module wl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
